@@ rtl/kol_pkg.sv @@
// Shared types, token codes, character classes and keyword table of the lexer.
package kol_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int INT_BITS_DEF      = 31;
	localparam int FIFO_DEPTH        = 4;
	localparam int PTR_W             = $clog2(FIFO_DEPTH);
	localparam int PREFIX_BYTES      = 5;
	localparam int PREFIX_W          = 8 * PREFIX_BYTES;

	localparam logic [3:0]  TAB_WIDTH_RST = 4'd4;
	localparam logic [15:0] RUN_MAX       = 16'hFFFF;

	// Register map: index taken from paddr[2].
	localparam logic REG_TAB_WIDTH = 1'b0;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_BAR   = 8'h7C;

	typedef enum logic [2:0] {
		M_LINE  = 3'd0,
		M_IDLE  = 3'd1,
		M_INT   = 3'd2,
		M_LABEL = 3'd3,
		M_EQ    = 3'd4,
		M_STAR  = 3'd5,
		M_BAR   = 3'd6
	} mode_t;

	typedef enum logic [4:0] {
		TK_NEWLINE  = 5'd0,
		TK_INT      = 5'd1,
		TK_LET      = 5'd2,
		TK_NOW      = 5'd3,
		TK_IF       = 5'd4,
		TK_ELSE     = 5'd5,
		TK_ANDW     = 5'd6,
		TK_ORW      = 5'd7,
		TK_XORW     = 5'd8,
		TK_IS       = 5'd9,
		TK_NOTW     = 5'd10,
		TK_BOOL     = 5'd11,
		TK_VAR      = 5'd12,
		TK_EQUALS   = 5'd13,
		TK_EXP      = 5'd14,
		TK_XOR      = 5'd15,
		TK_BIND     = 5'd16,
		TK_PLUS     = 5'd17,
		TK_MINUS    = 5'd18,
		TK_DIV      = 5'd19,
		TK_MULT     = 5'd20,
		TK_AND      = 5'd21,
		TK_OR       = 5'd22,
		TK_NOT      = 5'd23,
		TK_GREATER  = 5'd24,
		TK_LESS     = 5'd25,
		TK_LPAR     = 5'd26,
		TK_RPAR     = 5'd27,
		TK_BADCHAR  = 5'd28,
		TK_OVERFLOW = 5'd29
	} tok_kind_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_marker;
	} char_word_t;

	typedef struct packed {
		tok_kind_t   token_kind;
		logic [30:0] token_value;
		logic [15:0] text_position;
		logic [15:0] label_length;
		logic        last_of_run;
	} token_word_t;

	typedef struct packed {
		logic      hit;
		tok_kind_t kind;
		logic      bool_val;
	} kw_hit_t;

	typedef struct packed {
		logic      hit;
		tok_kind_t kind;
	} op_hit_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
			|| (c == 8'h5F);
	endfunction

	// Exact match of a short run against the keyword list, bytes packed big-endian.
	function automatic kw_hit_t kw_lookup(input logic [PREFIX_W-1:0] prefix,
			input logic [15:0] run);
		kw_hit_t r;
		r.hit      = 1'b1;
		r.kind     = TK_VAR;
		r.bool_val = 1'b0;
		if (run == 16'd3 && prefix == 40'h00_006C_6574) r.kind = TK_LET;
		else if (run == 16'd3 && prefix == 40'h00_006E_6F77) r.kind = TK_NOW;
		else if (run == 16'd2 && prefix == 40'h00_0000_6966) r.kind = TK_IF;
		else if (run == 16'd4 && prefix == 40'h00_656C_7365) r.kind = TK_ELSE;
		else if (run == 16'd3 && prefix == 40'h00_0061_6E64) r.kind = TK_ANDW;
		else if (run == 16'd2 && prefix == 40'h00_0000_6F72) r.kind = TK_ORW;
		else if (run == 16'd3 && prefix == 40'h00_0078_6F72) r.kind = TK_XORW;
		else if (run == 16'd2 && prefix == 40'h00_0000_6973) r.kind = TK_IS;
		else if (run == 16'd3 && prefix == 40'h00_006E_6F74) r.kind = TK_NOTW;
		else if (run == 16'd4 && prefix == 40'h00_7472_7565) begin
			r.kind     = TK_BOOL;
			r.bool_val = 1'b1;
		end else if (run == 16'd5 && prefix == 40'h66_616C_7365) r.kind = TK_BOOL;
		else r.hit = 1'b0;
		return r;
	endfunction

	// Operators that are complete after one character.
	function automatic op_hit_t single_op(input logic [7:0] c);
		op_hit_t r;
		r.hit  = 1'b1;
		r.kind = TK_PLUS;
		unique case (c)
			8'h2B: r.kind = TK_PLUS;
			8'h2D: r.kind = TK_MINUS;
			8'h2F: r.kind = TK_DIV;
			8'h26: r.kind = TK_AND;
			8'h21: r.kind = TK_NOT;
			8'h3E: r.kind = TK_GREATER;
			8'h3C: r.kind = TK_LESS;
			8'h28: r.kind = TK_LPAR;
			8'h29: r.kind = TK_RPAR;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/kol_stream_if.sv @@
// Valid/ready stream interface carrying one payload word per handshake.
interface kol_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/keyword_operator_lexer.sv @@
// Streaming lexer top level: character in, tokens out, tab width register.
//
// The lexer takes one source character per word on the chars stream and
// returns tokens on the tokens stream. Every accepted character is fully
// lexed in the cycle it is accepted: the pending-token state updates at that
// clock edge and the zero, one or two tokens it causes are written into a
// four-entry result queue. The chars stream is ready whenever the queue has
// two free entries, so characters go in at one per cycle as long as tokens
// are taken; tokens leave at one per cycle while the sink is ready, so a
// character that yields two tokens (a flushed token followed by an operator or
// error) occupies two queue entries. The end marker flushes the pending token
// and rearms the lexer for a new text with the tab width kept. After an
// unrecognized character or an integer overflow the error is sticky: further
// words are accepted and dropped until reset. The tab width register sits at
// byte address 0 and should only be written while no character is in flight.
// There is no memory and no clearing pass after reset.
module keyword_operator_lexer
	import kol_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	parameter int INT_BITS      = INT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	kol_stream_if.sink   chars,
	kol_stream_if.source tokens
);

	// Lexer state.
	mode_t                    mode_q;
	logic [INT_BITS-1:0]      acc_q;
	logic                     ovf_q;
	logic [PREFIX_W-1:0]      prefix_q;
	logic [POSITION_BITS-1:0] lstart_q;
	logic [15:0]              run_q;
	logic [15:0]              indent_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     err_q;
	logic [3:0]               tab_q;

	mode_t                    mode_d;
	logic [INT_BITS-1:0]      acc_d;
	logic                     ovf_d;
	logic [PREFIX_W-1:0]      prefix_d;
	logic [POSITION_BITS-1:0] lstart_d;
	logic [15:0]              run_d;
	logic [15:0]              indent_d;
	logic [POSITION_BITS-1:0] pos_d;
	logic                     err_d;

	// Result queue.
	token_word_t      fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;

	logic       accept;
	logic       pop;
	logic [7:0] c;
	logic       em;

	// Character classes and decode of what this character does.
	logic       c_dig, c_alp, c_ws, c_nl;
	logic [7:0] pair_char;
	logic       do_flush, do_fresh, do_pair;
	logic       line_ws, int_dig, lbl_ext;

	// Tokens that can come out of this character.
	token_word_t flush_tok, fresh_tok, pair_tok;
	logic        flush_emits, flush_err;
	logic        fresh_emits, fresh_bad;
	kw_hit_t     kw;
	op_hit_t     op;

	token_word_t      res0, res1;
	logic [1:0]       n_res;
	logic [INT_BITS+3:0] acc_w, prod;
	logic [16:0]      ind_sum;
	logic [3:0]       ind_incr;

	assign c      = chars.data.char_code;
	assign em     = chars.data.end_marker;
	assign accept = chars.valid && chars.ready;
	assign pop    = tokens.valid && tokens.ready;

	assign chars.ready  = (cnt_q <= (PTR_W+1)'(FIFO_DEPTH - 2));
	assign tokens.valid = (cnt_q != '0);
	assign tokens.data  = fifo_q[rd_q];

	// ---------------------------------------------------------------------
	// Configuration port. Only the tab width is writable; pready stays high.
	// ---------------------------------------------------------------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TAB_WIDTH) ? {28'b0, tab_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q <= TAB_WIDTH_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TAB_WIDTH) begin
			tab_q <= pwdata[3:0];
		end
	end

	// ---------------------------------------------------------------------
	// Decode: does the pending token get flushed, is the character lexed as
	// the start of a new token, or does it extend the pending one.
	// ---------------------------------------------------------------------
	always_comb begin
		c_dig = is_digit(c);
		c_alp = is_alpha(c);
		c_ws  = (c == CH_SPACE) || (c == CH_TAB);
		c_nl  = (c == CH_NL);
		unique case (mode_q)
			M_EQ:    pair_char = CH_EQ;
			M_STAR:  pair_char = CH_STAR;
			default: pair_char = CH_BAR;
		endcase
	end

	always_comb begin
		do_flush = 1'b0;
		do_fresh = 1'b0;
		do_pair  = 1'b0;
		line_ws  = 1'b0;
		int_dig  = 1'b0;
		lbl_ext  = 1'b0;
		if (!err_q) begin
			if (em) begin
				do_flush = 1'b1;
			end else begin
				unique case (mode_q)
					M_LINE: begin
						if (c_ws || c_nl) begin
							line_ws = 1'b1;
						end else begin
							do_flush = 1'b1;
							do_fresh = 1'b1;
						end
					end
					M_INT: begin
						if (c_dig) begin
							int_dig = 1'b1;
						end else begin
							// An overflowing integer ends lexing at this character.
							do_flush = 1'b1;
							do_fresh = !ovf_q;
						end
					end
					M_LABEL: begin
						if (c_dig || c_alp) begin
							lbl_ext = 1'b1;
						end else begin
							do_flush = 1'b1;
							do_fresh = 1'b1;
						end
					end
					M_EQ, M_STAR, M_BAR: begin
						if (c == pair_char) begin
							do_pair = 1'b1;
						end else begin
							do_flush = 1'b1;
							do_fresh = 1'b1;
						end
					end
					default: begin
						do_fresh = 1'b1;
					end
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------
	// Candidate tokens.
	// ---------------------------------------------------------------------
	always_comb begin
		kw = kw_lookup(prefix_q, run_q);
		op = single_op(c);

		flush_tok   = '{TK_NEWLINE, 31'b0, 16'b0, 16'b0, 1'b0};
		flush_emits = 1'b1;
		flush_err   = 1'b0;
		unique case (mode_q)
			M_LINE: flush_tok.token_value = {15'b0, indent_q};
			M_INT: begin
				if (ovf_q) begin
					flush_tok.token_kind    = TK_OVERFLOW;
					flush_tok.text_position = 16'(lstart_q);
					flush_err               = 1'b1;
				end else begin
					flush_tok.token_kind  = TK_INT;
					flush_tok.token_value = 31'(acc_q);
				end
			end
			M_LABEL: begin
				if (kw.hit) begin
					flush_tok.token_kind  = kw.kind;
					flush_tok.token_value = {30'b0, kw.bool_val};
				end else begin
					flush_tok.token_kind    = TK_VAR;
					flush_tok.text_position = 16'(lstart_q);
					flush_tok.label_length  = run_q;
				end
			end
			M_EQ:   flush_tok.token_kind = TK_BIND;
			M_STAR: flush_tok.token_kind = TK_MULT;
			M_BAR:  flush_tok.token_kind = TK_OR;
			default: flush_emits = 1'b0;
		endcase

		// A fresh character emits only single-character operators or an error.
		fresh_tok   = '{TK_BADCHAR, 31'b0, 16'b0, 16'b0, 1'b0};
		fresh_bad   = !(c_ws || c_nl || c_dig || c_alp || op.hit
			|| c == CH_EQ || c == CH_STAR || c == CH_BAR);
		fresh_emits = op.hit || fresh_bad;
		if (op.hit) begin
			fresh_tok.token_kind = op.kind;
		end else begin
			fresh_tok.text_position = 16'(pos_q);
		end

		pair_tok = '{TK_EQUALS, 31'b0, 16'b0, 16'b0, 1'b0};
		unique case (mode_q)
			M_STAR:  pair_tok.token_kind = TK_EXP;
			M_BAR:   pair_tok.token_kind = TK_XOR;
			default: pair_tok.token_kind = TK_EQUALS;
		endcase
	end

	// Order the results: flushed token first, then whatever the character makes.
	always_comb begin
		logic a, b;
		a     = do_flush && flush_emits;
		b     = do_fresh && fresh_emits;
		n_res = {1'b0, a} + {1'b0, b} + {1'b0, do_pair};
		res0  = a ? flush_tok : (b ? fresh_tok : pair_tok);
		res1  = fresh_tok;
		res0.last_of_run = (n_res == 2'd1);
		res1.last_of_run = 1'b1;
	end

	// ---------------------------------------------------------------------
	// Next state of the pending token.
	// ---------------------------------------------------------------------
	always_comb begin
		acc_w    = {4'b0, acc_q};
		prod     = (acc_w << 3) + (acc_w << 1) + {{INT_BITS{1'b0}}, c[3:0]};
		ind_incr = (c == CH_TAB) ? tab_q : 4'd1;
		ind_sum  = {1'b0, indent_q} + {13'b0, ind_incr};

		mode_d   = mode_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		prefix_d = prefix_q;
		lstart_d = lstart_q;
		run_d    = run_q;
		indent_d = indent_q;
		pos_d    = pos_q;
		err_d    = err_q;

		if (accept && !err_q) begin
			if (em) begin
				// Flush, then start a new text.
				err_d    = flush_err;
				mode_d   = M_LINE;
				acc_d    = '0;
				ovf_d    = 1'b0;
				prefix_d = '0;
				lstart_d = '0;
				run_d    = '0;
				indent_d = '0;
				pos_d    = '0;
			end else begin
				pos_d = pos_q + {{(POSITION_BITS-1){1'b0}}, 1'b1};
				if (line_ws) begin
					if (c_nl) indent_d = '0;
					else indent_d = ind_sum[16] ? RUN_MAX : ind_sum[15:0];
				end
				if (int_dig && !ovf_q) begin
					// Overflow when the new value exceeds the all-ones limit.
					if (prod[INT_BITS+3:INT_BITS] != 4'b0) ovf_d = 1'b1;
					else acc_d = prod[INT_BITS-1:0];
				end
				if (lbl_ext) begin
					if (run_q < 16'(PREFIX_BYTES)) prefix_d = {prefix_q[PREFIX_W-9:0], c};
					if (run_q != RUN_MAX) run_d = run_q + 16'd1;
				end
				if (do_pair) mode_d = M_IDLE;
				if (do_flush) begin
					mode_d = M_IDLE;
					if (flush_err) err_d = 1'b1;
				end
				if (do_fresh) begin
					if (c_nl) begin
						mode_d   = M_LINE;
						indent_d = '0;
					end else if (c_dig) begin
						mode_d   = M_INT;
						acc_d    = {{(INT_BITS-4){1'b0}}, c[3:0]};
						ovf_d    = 1'b0;
						lstart_d = pos_q;
					end else if (c_alp) begin
						mode_d   = M_LABEL;
						lstart_d = pos_q;
						run_d    = 16'd1;
						prefix_d = {{(PREFIX_W-8){1'b0}}, c};
					end else if (c == CH_EQ) begin
						mode_d = M_EQ;
					end else if (c == CH_STAR) begin
						mode_d = M_STAR;
					end else if (c == CH_BAR) begin
						mode_d = M_BAR;
					end else begin
						mode_d = M_IDLE;
					end
					if (fresh_bad) err_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_LINE;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			prefix_q <= '0;
			lstart_q <= '0;
			run_q    <= '0;
			indent_q <= '0;
			pos_q    <= '0;
			err_q    <= 1'b0;
		end else begin
			mode_q   <= mode_d;
			acc_q    <= acc_d;
			ovf_q    <= ovf_d;
			prefix_q <= prefix_d;
			lstart_q <= lstart_d;
			run_q    <= run_d;
			indent_q <= indent_d;
			pos_q    <= pos_d;
			err_q    <= err_d;
		end
	end

	// ---------------------------------------------------------------------
	// Result queue: up to two writes and one read per cycle.
	// ---------------------------------------------------------------------
	logic [1:0] n_push;
	assign n_push = accept ? n_res : 2'd0;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) fifo_q[wr_q] <= res0;
		if (n_push == 2'd2) fifo_q[PTR_W'(wr_q + 1'b1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= PTR_W'(wr_q + n_push);
			if (pop) rd_q <= PTR_W'(rd_q + 1'b1);
			cnt_q <= (PTR_W+1)'(cnt_q + n_push - {{PTR_W{1'b0}}, pop});
		end
	end

	// ---------------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------------
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PTR_W+1)'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error flag cleared without reset");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && err_q) |=> (cnt_q <= $past(cnt_q)))
		else $error("token produced after a latched error");

	a_end_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !err_q && em) |=> (mode_q == M_LINE && pos_q == '0))
		else $error("end marker did not restart the text");

endmodule
